### hdl/glos_pkg.sv
`timescale 1ns / 1ps
package glos_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  localparam int unsigned COORD_W  = 8;
  localparam int unsigned REG_W    = 9;
  localparam int unsigned STATE_W  = 2;
  localparam int unsigned ACC_W    = 17;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [REG_W-1:0] GRID_WIDTH_RST  = 9'd200;
  localparam logic [REG_W-1:0] GRID_HEIGHT_RST = 9'd150;

  localparam logic [STATE_W-1:0] CELL_UNKNOWN = 2'd0;
  localparam logic [STATE_W-1:0] CELL_FREE    = 2'd1;

  localparam logic [1:0] DIAG_FIRST  = 2'd0;
  localparam logic [1:0] DIAG_SECOND = 2'd1;
  localparam logic [1:0] DIAG_LAST   = 2'd2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } back_state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic               neg_x;
    logic               neg_y;
    logic [STATE_W-1:0] wr_state;
    logic               wr_ok;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

### hdl/glos_ram.sv
`timescale 1ns / 1ps
module glos_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/glos_front.sv
`timescale 1ns / 1ps
module glos_front #(
  parameter int unsigned MAX_WIDTH  = glos_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = glos_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    cmd_i,
  input  logic [glos_pkg::COORD_W-1:0]            start_x_i,
  input  logic [glos_pkg::COORD_W-1:0]            start_y_i,
  input  logic [glos_pkg::COORD_W-1:0]            end_x_i,
  input  logic [glos_pkg::COORD_W-1:0]            end_y_i,
  input  logic [glos_pkg::STATE_W-1:0]            write_state_i,
  input  glos_pkg::queue_status_t                 q_status_i,
  input  glos_pkg::back_status_t                  b_status_i,
  output logic                                    push_o,
  output glos_pkg::job_t                          job_o
);
  import glos_pkg::*;

  assign in_ready_o = !q_status_i.full && !b_status_i.clearing;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    job_o.cmd      = cmd_e'(cmd_i);
    job_o.x        = start_x_i;
    job_o.y        = start_y_i;
    job_o.neg_x    = end_x_i < start_x_i;
    job_o.neg_y    = end_y_i < start_y_i;
    job_o.nx       = job_o.neg_x ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    job_o.ny       = job_o.neg_y ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    job_o.wr_state = write_state_i;
    job_o.wr_ok    = (32'(start_x_i) < MAX_WIDTH) && (32'(start_y_i) < MAX_HEIGHT);
  end

endmodule

### hdl/glos_queue.sv
`timescale 1ns / 1ps
module glos_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  glos_pkg::job_t          job_i,
  input  logic                    pop_i,
  output glos_pkg::job_t          job_o,
  output logic                    job_valid_o,
  output glos_pkg::queue_status_t status_o
);
  import glos_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  job_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full  = count_q == (PtrW+1)'(QUEUE_DEPTH);
  assign status_o.empty = count_q == '0;
  assign job_valid_o    = !status_o.empty;
  assign job_o          = slot_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### hdl/glos_back.sv
`timescale 1ns / 1ps
module glos_back #(
  parameter int unsigned MAX_WIDTH  = glos_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = glos_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  glos_pkg::job_t               job_i,
  input  logic                         job_valid_i,
  output logic                         job_pop_o,
  input  logic [glos_pkg::REG_W-1:0]   grid_width_i,
  input  logic [glos_pkg::REG_W-1:0]   grid_height_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         path_clear_o,
  output glos_pkg::back_status_t       status_o
);
  import glos_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);

  function automatic logic [AddrW-1:0] addr_of(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
    addr_of = AddrW'(32'(y) * MAX_WIDTH + 32'(x));
  endfunction

  back_state_e        state_q, state_d;
  logic [AddrW-1:0]   clr_addr_q, clr_addr_d;
  logic               probe_vld_q, probe_vld_d;
  logic               probe_oob_q, probe_oob_d;
  logic               out_valid_q, out_valid_d;
  logic               path_clear_q, path_clear_d;
  logic               res_q, res_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [COORD_W-1:0] ix_q, ix_d, iy_q, iy_d;
  logic [COORD_W-1:0] nx_q, nx_d, ny_q, ny_d;
  logic               neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [ACC_W-1:0]   lhs_q, lhs_d, rhs_q, rhs_d;
  logic [1:0]         k_q, k_d;

  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [STATE_W-1:0] ram_wdata, ram_rdata;

  logic               clr_last, gen_done, blocked, out_free;
  logic               tie, go_x, use_x_adj, use_y_adj, last_cell, cell_oob, issue;
  logic [COORD_W-1:0] x_adj, y_adj, cell_x, cell_y;

  glos_ram #(
    .WIDTH (STATE_W),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign clr_last = clr_addr_q == AddrW'(Depth - 1);
  assign gen_done = (ix_q == nx_q) && (iy_q == ny_q);
  assign blocked  = probe_vld_q && (probe_oob_q || (ram_rdata != CELL_FREE));
  assign out_free = !out_valid_q || out_ready_i;

  // next cell of the supercover walk
  assign tie       = lhs_q == rhs_q;
  assign go_x      = lhs_q < rhs_q;
  assign x_adj     = neg_x_q ? x_q - 1'b1 : x_q + 1'b1;
  assign y_adj     = neg_y_q ? y_q - 1'b1 : y_q + 1'b1;
  assign use_x_adj = tie ? (k_q != DIAG_SECOND) : go_x;
  assign use_y_adj = tie ? (k_q != DIAG_FIRST) : !go_x;
  assign cell_x    = use_x_adj ? x_adj : x_q;
  assign cell_y    = use_y_adj ? y_adj : y_q;
  assign last_cell = !tie || (k_q == DIAG_LAST);
  assign cell_oob  = ({1'b0, cell_x} >= grid_width_i) || (32'(cell_x) >= MAX_WIDTH) ||
                     ({1'b0, cell_y} >= grid_height_i) || (32'(cell_y) >= MAX_HEIGHT);
  assign issue     = (state_q == ST_WALK) && !blocked && !gen_done;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (job_valid_i && job_i.cmd == CMD_QUERY) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (blocked || (gen_done && !probe_vld_q)) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    clr_addr_d   = clr_addr_q;
    probe_vld_d  = 1'b0;
    probe_oob_d  = cell_oob;
    out_valid_d  = out_valid_q && !out_ready_i;
    path_clear_d = path_clear_q;
    res_d        = res_q;
    x_d          = x_q;
    y_d          = y_q;
    ix_d         = ix_q;
    iy_d         = iy_q;
    nx_d         = nx_q;
    ny_d         = ny_q;
    neg_x_d      = neg_x_q;
    neg_y_d      = neg_y_q;
    lhs_d        = lhs_q;
    rhs_d        = rhs_q;
    k_d          = k_q;
    job_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = addr_of(job_i.x, job_i.y);
    ram_wdata    = job_i.wr_state;
    ram_re       = issue && !cell_oob;
    ram_raddr    = addr_of(cell_x, cell_y);

    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = CELL_UNKNOWN;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (job_i.cmd == CMD_WRITE) begin
            ram_we = job_i.wr_ok;
          end else begin
            x_d     = job_i.x;
            y_d     = job_i.y;
            nx_d    = job_i.nx;
            ny_d    = job_i.ny;
            neg_x_d = job_i.neg_x;
            neg_y_d = job_i.neg_y;
            ix_d    = '0;
            iy_d    = '0;
            lhs_d   = ACC_W'(job_i.ny);
            rhs_d   = ACC_W'(job_i.nx);
            k_d     = DIAG_FIRST;
          end
        end
      end
      ST_WALK: begin
        if (blocked) begin
          res_d = 1'b0;
        end else if (gen_done) begin
          res_d = 1'b1;
        end else begin
          probe_vld_d = 1'b1;
          if (last_cell) begin
            x_d = cell_x;
            y_d = cell_y;
            k_d = DIAG_FIRST;
            if (tie || go_x) begin
              ix_d  = ix_q + 1'b1;
              lhs_d = lhs_q + ACC_W'({ny_q, 1'b0});
            end
            if (tie || !go_x) begin
              iy_d  = iy_q + 1'b1;
              rhs_d = rhs_q + ACC_W'({nx_q, 1'b0});
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          path_clear_d = res_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      probe_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      probe_vld_q <= probe_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_oob_q  <= probe_oob_d;
    path_clear_q <= path_clear_d;
    res_q        <= res_d;
    x_q          <= x_d;
    y_q          <= y_d;
    ix_q         <= ix_d;
    iy_q         <= iy_d;
    nx_q         <= nx_d;
    ny_q         <= ny_d;
    neg_x_q      <= neg_x_d;
    neg_y_q      <= neg_y_d;
    lhs_q        <= lhs_d;
    rhs_q        <= rhs_d;
    k_q          <= k_d;
  end

  assign out_valid_o       = out_valid_q;
  assign path_clear_o      = path_clear_q;
  assign status_o.clearing = state_q == ST_CLEAR;

endmodule

### hdl/grid_line_of_sight_check.sv
`timescale 1ns / 1ps
// line-of-sight checker over a 2-bit occupancy grid (unknown, free, occupied)
// input channel: in_valid_i / in_ready_o; cmd_i selects a cell write or a query
// a write stores write_state_i at (start_x_i, start_y_i) and gives no result
// a query walks the supercover line from start to end and returns one item on
// the output channel (out_valid_o / out_ready_i): path_clear_o is 1 when every
// crossed cell is free and inside grid_width x grid_height
// config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 width, 1 height)
// at once; the user must write only while the block is idle (unchecked)
// after reset the store is swept to unknown, one entry per cycle, over all
// MAX_WIDTH * MAX_HEIGHT entries (65536 by default); in_ready_o stays low then
// a query reads the store once per probed cell, one read per cycle while it
// walks, and three reads per diagonal step
// a two-entry queue takes new items while a walk runs or a result waits
// a stalled receiver holds the result in the output register, the walker then
// waits and the queue fills, after which in_ready_o drops
module grid_line_of_sight_check #(
  parameter int unsigned MAX_WIDTH  = glos_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = glos_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [glos_pkg::COORD_W-1:0]  start_x_i,
  input  logic [glos_pkg::COORD_W-1:0]  start_y_i,
  input  logic [glos_pkg::COORD_W-1:0]  end_x_i,
  input  logic [glos_pkg::COORD_W-1:0]  end_y_i,
  input  logic [glos_pkg::STATE_W-1:0]  write_state_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          path_clear_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [glos_pkg::REG_W-1:0]    cfg_wdata_i
);
  import glos_pkg::*;

  logic [REG_W-1:0] grid_width_q, grid_width_d;
  logic [REG_W-1:0] grid_height_q, grid_height_d;
  logic             push, job_valid, job_pop;
  job_t             front_job, queue_job;
  queue_status_t    q_status;
  back_status_t     b_status;

  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:  grid_width_d  = cfg_wdata_i;
        REG_GRID_HEIGHT: grid_height_d = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
    end else begin
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
    end
  end

  glos_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .write_state_i (write_state_i),
    .q_status_i    (q_status),
    .b_status_i    (b_status),
    .push_o        (push),
    .job_o         (front_job)
  );

  glos_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (front_job),
    .pop_i       (job_pop),
    .job_o       (queue_job),
    .job_valid_o (job_valid),
    .status_o    (q_status)
  );

  glos_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (queue_job),
    .job_valid_i   (job_valid),
    .job_pop_o     (job_pop),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .path_clear_o  (path_clear_o),
    .status_o      (b_status)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.clearing |-> !in_ready_o)
    else $error("item taken during store sweep");

  a_queue_status_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("queue popped while empty");

endmodule
